FILE: rtl/lbs_pkg.sv
// shared types and constants for the bridge forwarding and spanning-tree engine
`default_nettype none
package lbs_pkg;

  localparam int TableDepthDef = 64;
  localparam int PortsDef      = 8;

  localparam logic [1:0] ModeData  = 2'd0;
  localparam logic [1:0] ModeBpdu  = 2'd1;
  localparam logic [1:0] ModeHello = 2'd2;

  localparam logic [1:0] RoleUnknown    = 2'd0;
  localparam logic [1:0] RoleRoot       = 2'd1;
  localparam logic [1:0] RoleDesignated = 2'd2;
  localparam logic [1:0] RoleBlocked    = 2'd3;

  localparam logic RegOwnId       = 1'b0;
  localparam logic RegActivePorts = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StLearn,
    StLookup,
    StEmit,
    StFlood,
    StHello
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  ingress_port;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [63:0] rx_root_id;
    logic [31:0] rx_root_cost;
    logic [63:0] rx_sender_id;
    logic [15:0] ingress_link_cost;
  } req_t;

  typedef struct packed {
    logic [2:0]  egress_port;
    logic        out_kind;
    logic [63:0] tx_root_id;
    logic [31:0] tx_root_cost;
    logic [63:0] tx_bridge_id;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/learning_bridge_stp_engine_top.sv
// top level: mac learning table, forwarding decision and spanning-tree state
//
//  channel  | signals                              | handshake
//  request  | start_i, req_i                       | taken when start_i && !busy_o
//  result   | res_valid_o, res_o                   | one cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i      | write when cfg_we_i
//
// a data frame scans the table entry by entry for the source, passes the learn state,
// scans the table for the destination, then emits to the found port or floods the
// other active ports; the scan length is set by the single table read port. a frame
// on a blocked port ends in the search state. a bpdu passes the learn state only, a
// hello tick walks each active port. reset clears control state; the table needs no
// clearing since only filled entries are read. results cannot be stalled.
`default_nettype none
module learning_bridge_stp_engine_top import lbs_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire req_t        req_i,
  output      logic        res_valid_o,
  output      res_t        res_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int PORTS = PortsDef;
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(PORTS + 1);
  localparam int RW = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam logic [PW-1:0] PortsC = PW'(PORTS);
  localparam logic [3:0] NoPort = 4'hf;

  logic [47:0] mem_mac [TABLE_DEPTH];
  logic [2:0]  mem_port[TABLE_DEPTH];

  state_e      state_q, state_d;
  req_t        req_q;
  logic [63:0] own_id_q;
  logic [3:0]  act_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [63:0] root_q, root_d;
  logic [31:0] rcost_q, rcost_d;
  logic [3:0]  rport_q, rport_d;
  logic [1:0]  role_q[PORTS];
  logic [1:0]  role_d[PORTS];
  logic [PW-1:0] p_q, p_d;
  logic [2:0]  hit_port_q, hit_port_d;
  logic        pend_q, pend_d;
  logic [2:0]  pend_port_q, pend_port_d;
  logic        pend_kind_q, pend_kind_d;

  logic [47:0] rd_mac;
  logic [2:0]  rd_port;
  logic        we;
  logic [AW-1:0] wa;
  logic [2:0]  wport;

  logic [PW-1:0] lim;
  logic [32:0] via_sum;
  logic [31:0] via;
  logic        better, nb_better, ing_ok;
  logic [RW-1:0] ing_r, pr;
  logic        emit, emit_kind;
  logic [2:0]  emit_port;

  assign lim = (PW'(act_q) > PortsC) ? PortsC : PW'(act_q);
  assign busy_o = (state_q != StIdle);

  // table read at the scan index, registered data
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_mac[wa]  <= req_q.src_mac;
      mem_port[wa] <= wport;
    end
    rd_mac  <= mem_mac[idx_q[AW-1:0]];
    rd_port <= mem_port[idx_q[AW-1:0]];
  end

  assign via_sum = {1'b0, req_q.rx_root_cost} + 33'(req_q.ingress_link_cost);
  assign via = via_sum[32] ? 32'hffff_ffff : via_sum[31:0];
  assign ing_r = RW'(req_q.ingress_port);
  assign pr = RW'(p_q);

  always_comb begin
    better = 1'b0;
    if (req_q.rx_root_id < root_q) better = 1'b1;
    else if (req_q.rx_root_id == root_q) begin
      if (rport_q == NoPort && own_id_q != root_q) better = 1'b1;
      else if (via < rcost_q) better = 1'b1;
      else if (via == rcost_q && {1'b0, req_q.ingress_port} < rport_q) better = 1'b1;
    end
    nb_better = (req_q.rx_root_cost < rcost_q) ||
                (req_q.rx_root_cost == rcost_q && req_q.rx_sender_id < own_id_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    ing_ok  = PW'(req_i.ingress_port) < lim;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          case (req_i.mode)
            ModeHello: state_d = StHello;
            ModeData:  if (ing_ok) state_d = StSearch;
            ModeBpdu:  if (ing_ok) state_d = StLearn;
            default:   state_d = StIdle;
          endcase
        end
      end
      StSearch: begin
        if (role_q[ing_r] == RoleBlocked) state_d = StIdle;
        else if (idx_q >= cnt_q) state_d = StLearn;
        else if (idx_q != '0 && rd_mac == req_q.src_mac) state_d = StLearn;
      end
      StLearn: state_d = (req_q.mode == ModeBpdu) ? StIdle : StLookup;
      StLookup: begin
        if (idx_q != '0 && rd_mac == req_q.dst_mac) state_d = StEmit;
        else if (idx_q >= cnt_q) state_d = StFlood;
      end
      StEmit:  state_d = StIdle;
      StFlood: if (p_q >= lim) state_d = StIdle;
      StHello: if (p_q >= lim) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d = cnt_q; idx_d = idx_q; root_d = root_q; rcost_d = rcost_q;
    rport_d = rport_q; p_d = p_q; hit_port_d = hit_port_q;
    pend_d = pend_q; pend_port_d = pend_port_q; pend_kind_d = pend_kind_q;
    for (int i = 0; i < PORTS; i++) role_d[i] = role_q[i];
    we = 1'b0; wa = idx_q[AW-1:0]; wport = req_q.ingress_port;
    emit = 1'b0; emit_kind = 1'b0; emit_port = 3'(p_q);
    case (state_q)
      StIdle: begin
        idx_d = '0; p_d = '0; pend_d = 1'b0;
      end
      StSearch: begin
        // read data is registered: rd_mac holds entry idx_q-1
        if (role_q[ing_r] == RoleBlocked) begin
          idx_d = '0;
        end else if (idx_q != '0 && rd_mac == req_q.src_mac) begin
          we = 1'b1; wa = AW'(idx_q - 1'b1);
          idx_d = '0;
          hit_port_d = 3'd0;
          p_d = '1;
        end else if (idx_q >= cnt_q) begin
          if (cnt_q < CW'(TABLE_DEPTH)) begin
            we = 1'b1; wa = cnt_q[AW-1:0]; cnt_d = cnt_q + 1'b1;
          end
          idx_d = '0;
        end else idx_d = idx_q + 1'b1;
      end
      StLearn: begin
        idx_d = '0; p_d = '0;
        if (req_q.mode == ModeBpdu) begin
          if (better) begin
            root_d = req_q.rx_root_id; rcost_d = via;
            rport_d = {1'b0, req_q.ingress_port};
            for (int i = 0; i < PORTS; i++)
              if (PW'(i) < lim)
                role_d[i] = (i == int'(req_q.ingress_port)) ? RoleRoot : RoleDesignated;
          end else if (req_q.rx_root_id == root_q && own_id_q != root_q &&
                       {1'b0, req_q.ingress_port} != rport_q) begin
            if (nb_better) role_d[ing_r] = RoleBlocked;
            else if (role_q[ing_r] != RoleRoot && role_q[ing_r] != RoleBlocked)
              role_d[ing_r] = RoleDesignated;
          end else if (own_id_q == root_q) role_d[ing_r] = RoleDesignated;
        end
      end
      StLookup: begin
        if (idx_q != '0 && rd_mac == req_q.dst_mac) hit_port_d = rd_port;
        else idx_d = idx_q + 1'b1;
      end
      StEmit: begin
        if (hit_port_q != req_q.ingress_port && PW'(hit_port_q) < lim &&
            role_q[RW'(hit_port_q)] != RoleBlocked) begin
          if (pend_q) begin
            emit = 1'b1; emit_port = pend_port_q; emit_kind = pend_kind_q;
          end
          pend_d = 1'b1; pend_port_d = hit_port_q; pend_kind_d = 1'b0;
        end
      end
      StFlood, StHello: begin
        if (p_q < lim) begin
          p_d = p_q + 1'b1;
          if ((state_q == StHello || pr != ing_r) && role_q[pr] != RoleBlocked) begin
            if (state_q == StHello && role_q[pr] == RoleUnknown)
              role_d[pr] = RoleDesignated;
            if (pend_q) begin
              emit = 1'b1; emit_port = pend_port_q; emit_kind = pend_kind_q;
            end
            pend_d = 1'b1; pend_port_d = 3'(p_q); pend_kind_d = (state_q == StHello);
          end
        end
      end
      default: ;
    endcase
    // the final held result leaves with last set when the item ends
    if (state_q != StIdle && state_d == StIdle && !emit && pend_d) begin
      emit = 1'b1; emit_port = pend_port_d; emit_kind = pend_kind_d;
      pend_d = 1'b0;
    end
    // a new own id also becomes the root while no root port exists
    if (cfg_we_i && cfg_idx_i == RegOwnId && rport_q == NoPort) root_d = cfg_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; own_id_q <= '0; act_q <= 4'd8; cnt_q <= '0; idx_q <= '0;
      root_q <= '0; rcost_q <= '0; rport_q <= NoPort; p_q <= '0; hit_port_q <= '0;
      pend_q <= 1'b0; pend_port_q <= '0; pend_kind_q <= 1'b0;
      for (int i = 0; i < PORTS; i++) role_q[i] <= RoleUnknown;
      res_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d;
      root_q <= root_d; rcost_q <= rcost_d; rport_q <= rport_d; p_q <= p_d;
      hit_port_q <= hit_port_d; pend_q <= pend_d; pend_port_q <= pend_port_d;
      pend_kind_q <= pend_kind_d;
      for (int i = 0; i < PORTS; i++) role_q[i] <= role_d[i];
      res_valid_o <= emit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegOwnId: own_id_q <= cfg_data_i;
          RegActivePorts: act_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) req_q <= req_i;
    if (emit) begin
      res_o.egress_port  <= emit_port;
      res_o.out_kind     <= emit_kind;
      res_o.tx_root_id   <= emit_kind ? root_q : 64'd0;
      res_o.tx_root_cost <= emit_kind ? rcost_q : 32'd0;
      res_o.tx_bridge_id <= emit_kind ? own_id_q : 64'd0;
      res_o.last         <= !pend_d;
    end
  end

endmodule
`default_nettype wire
